// ----- design/character_cell_video_scanout_core_defines.svh -----
// Assertion macros used by the character-cell scanout top level.
`ifndef CHARACTER_CELL_VIDEO_SCANOUT_CORE_DEFINES_SVH
`define CHARACTER_CELL_VIDEO_SCANOUT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define CCVS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ccvs check failed");
// Clocked check that also holds through reset.
`define CCVS_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ccvs check failed");
`else
`define CCVS_ASSERT(label, clk, rstn, prop)
`define CCVS_ASSERT_NR(label, clk, prop)
`endif

`endif

// ----- design/ccvs_pkg.sv -----
// Shared types and constants of the character-cell video scanout core.
package ccvs_pkg;

    // Store geometry.
    localparam int ADDR_W       = 13;
    localparam int STORE_BYTES  = 6912;
    localparam int BITMAP_BYTES = 6144;

    // Raster geometry of the bitmap area.
    localparam int SCREEN_TOP   = 60;
    localparam int SCREEN_LINES = 192;
    localparam int SCREEN_COLS  = 32;

    // Stream widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Item kinds carried in s_tuser.
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Pixel levels.
    localparam logic [7:0] DIM_LEVEL    = 8'd192;
    localparam logic [7:0] BRIGHT_LEVEL = 8'd255;

    // Write and read request to the video store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              re;
        logic [ADDR_W-1:0] rd_addr;
    } vram_req_t;

endpackage

// ----- design/ccvs_vram.sv -----
// Video store: 6912 bytes, one write port and one registered read port.
module ccvs_vram (
    input  logic                aclk,
    input  ccvs_pkg::vram_req_t req,
    output logic [7:0]          rd_data
);
    import ccvs_pkg::*;

    logic [7:0] mem [0:STORE_BYTES-1];
    logic [7:0] rd_data_reg;

    // Writes beyond the store are dropped; the read data is registered.
    always_ff @(posedge aclk) begin
        if (req.we && (req.wr_addr < ADDR_W'(STORE_BYTES))) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/character_cell_video_scanout_core.sv -----
// Top level of the character-cell video scanout core.
`include "character_cell_video_scanout_core_defines.svh"

// Each input word either writes one byte of the 6912-byte video store or renders one
// 8-pixel cell of a raster line; a rendered cell leaves as eight output words, the
// eighth marked by m_tlast. A write, or a render outside the visible window, leaves the
// fetch logic idle. A bitmap cell passes through the fetch states in turn (accept,
// attribute read, bitmap read, read data, hand-off) since the single read port of the
// store is used twice; a border cell goes from accept straight to hand-off. The fetch
// of the next cell overlaps the eight output words of the current one, so with a sink
// that is always ready the words of successive cells can follow without a gap. The store
// holds undefined data after reset; render only cells whose bytes have been written.
module character_cell_video_scanout_core #(
    parameter int BORDER_COLS = 4,
    parameter int BORDER_ROWS = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mem_addr[12:0], mem_data[20:13], line[29:21], column[35:30], border_color[38:36]
    input  logic [ccvs_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // red[7:0], green[15:8], blue[23:16], attribute[31:24]
    output logic [ccvs_pkg::M_TDATA_W-1:0]   m_tdata,
    // from_screen
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import ccvs_pkg::*;

    // Window limits.
    localparam logic [8:0] WIN_TOP   = 9'(SCREEN_TOP - 8 * BORDER_ROWS);
    localparam logic [8:0] WIN_BOT   = 9'(SCREEN_TOP + SCREEN_LINES + 8 * BORDER_ROWS);
    localparam logic [8:0] SCR_TOP   = 9'(SCREEN_TOP);
    localparam logic [8:0] SCR_BOT   = 9'(SCREEN_TOP + SCREEN_LINES);
    localparam logic [5:0] WIN_COLS  = 6'(SCREEN_COLS + 2 * BORDER_COLS);
    localparam logic [5:0] SCR_LEFT  = 6'(BORDER_COLS);
    localparam logic [5:0] SCR_RIGHT = 6'(BORDER_COLS + SCREEN_COLS);

    // Fetch states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ATTR = 3'd1;
    localparam logic [2:0] ST_BITS = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    // Input word fields.
    logic              in_mode;
    logic [ADDR_W-1:0] in_addr;
    logic [7:0]        in_data;
    logic [8:0]        in_line;
    logic [5:0]        in_col;
    logic [2:0]        in_border;

    assign in_mode   = s_tuser;
    assign in_addr   = s_tdata[12:0];
    assign in_data   = s_tdata[20:13];
    assign in_line   = s_tdata[29:21];
    assign in_col    = s_tdata[35:30];
    assign in_border = s_tdata[38:36];

    logic              in_fire;
    logic              in_visible;
    logic              in_screen;
    logic [8:0]        y_off;
    logic [5:0]        x_off;
    logic [4:0]        char_row;
    logic [ADDR_W-1:0] attr_addr;
    logic [ADDR_W-1:0] bits_addr;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic              cell_screen_reg;
    logic [2:0]        cell_border_reg;
    logic [ADDR_W-1:0] attr_addr_reg;
    logic [ADDR_W-1:0] bits_addr_reg;
    logic [7:0]        cell_attr_reg;
    logic [7:0]        cell_bits_reg;

    vram_req_t         vram_req;
    logic [7:0]        vram_rd_data;

    logic              out_valid_reg;
    logic [2:0]        pix_cnt_reg;
    logic [7:0]        out_bits_reg;
    logic [7:0]        out_attr_reg;
    logic [2:0]        out_ink_reg;
    logic [2:0]        out_paper_reg;
    logic              out_screen_reg;
    logic              out_fire;
    logic              load_ok;
    logic              load;
    logic [2:0]        pix_color;
    logic [7:0]        pix_level;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Classify the cell and form its two store addresses.
    always_comb begin
        in_visible = (in_line >= WIN_TOP) && (in_line < WIN_BOT) && (in_col < WIN_COLS);
        in_screen  = (in_line >= SCR_TOP) && (in_line < SCR_BOT) &&
                     (in_col >= SCR_LEFT) && (in_col < SCR_RIGHT);
        y_off      = in_line - SCR_TOP;
        x_off      = in_col - SCR_LEFT;
        char_row   = y_off[7:3];
        attr_addr  = ADDR_W'(BITMAP_BYTES) + {3'b000, char_row, x_off[4:0]};
        // Third, pixel line in the row, row in the third, column.
        bits_addr  = {char_row[4:3], y_off[2:0], char_row[2:0], x_off[4:0]};
    end

    // Store port: writes come straight from the input, reads from the fetch states.
    always_comb begin
        vram_req.we      = in_fire && (in_mode == MODE_WRITE);
        vram_req.wr_addr = in_addr;
        vram_req.wr_data = in_data;
        vram_req.re      = (state_reg == ST_ATTR) || (state_reg == ST_BITS);
        vram_req.rd_addr = (state_reg == ST_ATTR) ? attr_addr_reg : bits_addr_reg;
    end

    ccvs_vram u_vram (
        .aclk    (aclk),
        .req     (vram_req),
        .rd_data (vram_rd_data)
    );

    // The fetched cell moves to the pixel stage once that stage is empty or finishing.
    assign out_fire = out_valid_reg && m_tready;
    assign load_ok  = !out_valid_reg || (m_tready && (pix_cnt_reg == 3'd7));
    assign load     = (state_reg == ST_LOAD) && load_ok;

    // Fetch sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (in_mode == MODE_RENDER) && in_visible) begin
                    state_next = in_screen ? ST_ATTR : ST_LOAD;
                end
            end
            ST_ATTR: state_next = ST_BITS;
            ST_BITS: state_next = ST_DATA;
            ST_DATA: state_next = ST_LOAD;
            ST_LOAD: begin
                if (load_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Cell held by the fetch logic.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cell_screen_reg <= in_screen;
            cell_border_reg <= in_border;
            attr_addr_reg   <= attr_addr;
            bits_addr_reg   <= bits_addr;
        end
        if (state_reg == ST_BITS) begin
            cell_attr_reg <= vram_rd_data;
        end
        if (state_reg == ST_DATA) begin
            cell_bits_reg <= vram_rd_data;
        end
    end

    // Pixel stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pix_cnt_reg   <= 3'd0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            pix_cnt_reg   <= 3'd0;
        end else if (out_fire) begin
            pix_cnt_reg <= pix_cnt_reg + 3'd1;
            if (pix_cnt_reg == 3'd7) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pixel stage payload; a border cell shows its colour on every pixel.
    always_ff @(posedge aclk) begin
        if (load) begin
            if (cell_screen_reg) begin
                out_bits_reg   <= cell_bits_reg;
                out_attr_reg   <= cell_attr_reg;
                out_ink_reg    <= cell_attr_reg[2:0];
                out_paper_reg  <= cell_attr_reg[5:3];
                out_screen_reg <= 1'b1;
            end else begin
                out_bits_reg   <= 8'hFF;
                out_attr_reg   <= 8'h00;
                out_ink_reg    <= cell_border_reg;
                out_paper_reg  <= cell_border_reg;
                out_screen_reg <= 1'b0;
            end
        end else if (out_fire) begin
            out_bits_reg <= {out_bits_reg[6:0], 1'b0};
        end
    end

    // Current pixel: colour bit 0 is blue, bit 1 red, bit 2 green.
    always_comb begin
        pix_color = out_bits_reg[7] ? out_ink_reg : out_paper_reg;
        pix_level = out_attr_reg[6] ? BRIGHT_LEVEL : DIM_LEVEL;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_attr_reg,
                       pix_color[0] ? pix_level : 8'd0,
                       pix_color[2] ? pix_level : 8'd0,
                       pix_color[1] ? pix_level : 8'd0};
    assign m_tuser  = out_screen_reg;
    assign m_tlast  = (pix_cnt_reg == 3'd7);

    // A partly sent cell keeps the output valid.
    `CCVS_ASSERT(a_cnt_needs_valid, aclk, aresetn, (pix_cnt_reg != 3'd0) |-> out_valid_reg)
    // The bitmap read always follows the attribute read.
    `CCVS_ASSERT(a_attr_then_bits, aclk, aresetn, (state_reg == ST_ATTR) |=> (state_reg == ST_BITS))
    // The last pixel taken with nothing waiting empties the output.
    `CCVS_ASSERT(a_last_drains, aclk, aresetn, (out_fire && m_tlast && !load) |=> !m_tvalid)
    // Reset leaves the block ready for input with no output pending.
    `CCVS_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> (s_tready && !m_tvalid))

endmodule

// ----- bench/character_cell_video_scanout_core_test.sv -----
// Self-checking testbench for the character-cell video scanout core.
module character_cell_video_scanout_core_test;
    import ccvs_pkg::*;

    localparam int BORDER_COLS  = 4;
    localparam int BORDER_ROWS  = 3;
    localparam int FIRST_LINE   = SCREEN_TOP - 8 * BORDER_ROWS;
    localparam int END_LINE     = SCREEN_TOP + SCREEN_LINES + 8 * BORDER_ROWS;
    localparam int END_COL      = SCREEN_COLS + 2 * BORDER_COLS;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;

    // One expected output word: one pixel of a rendered cell.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] attribute;
        logic       from_screen;
        logic       last;
    } pixel_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Shadow copy of the video store and which bytes have been written.
    logic [7:0] shadow_store [STORE_BYTES];
    bit         byte_written [STORE_BYTES];

    pixel_t expected_pixels [$];
    pixel_t want_px;
    int     error_count  = 0;
    int     idle_pct     = 0;
    int     stall_pct    = 0;
    int     hold_left    = 0;
    int     quiet_cycles = 0;

    character_cell_video_scanout_core #(
        .BORDER_COLS(BORDER_COLS),
        .BORDER_ROWS(BORDER_ROWS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Geometry helpers in raster coordinates.
    function automatic bit is_screen(int ln, int col);
        return ln >= SCREEN_TOP && ln < SCREEN_TOP + SCREEN_LINES &&
               col >= BORDER_COLS && col < BORDER_COLS + SCREEN_COLS;
    endfunction

    function automatic int attr_addr(int ln, int col);
        return BITMAP_BYTES + (col - BORDER_COLS) + (((ln - SCREEN_TOP) >> 3) << 5);
    endfunction

    // Bitmap layout: third of the screen, then pixel line, then character row.
    function automatic int bitmap_addr(int ln, int col);
        int yl;
        int row;
        yl  = ln - SCREEN_TOP;
        row = yl >> 3;
        return 2048 * (row >> 3) + (col - BORDER_COLS) + (row & 7) * 32 + 256 * (yl & 7);
    endfunction

    function automatic void store_byte(int addr, logic [7:0] data);
        if (addr < STORE_BYTES) begin
            shadow_store[addr] = data;
            byte_written[addr] = 1'b1;
        end
    endfunction

    // Queue the eight pixels that a render word produces, if any.
    function automatic void predict_cell(int ln, int col, logic [2:0] border);
        logic [7:0] attr;
        logic [7:0] bits;
        logic [7:0] level;
        logic [2:0] colour;
        bit         screen;
        pixel_t     px;
        if (ln < FIRST_LINE || ln >= END_LINE || col >= END_COL)
            return;
        screen = is_screen(ln, col);
        attr   = screen ? shadow_store[attr_addr(ln, col)] : 8'd0;
        bits   = screen ? shadow_store[bitmap_addr(ln, col)] : 8'd0;
        for (int k = 0; k < 8; k++) begin
            if (screen) begin
                colour = bits[7 - k] ? attr[2:0] : attr[5:3];
                level  = attr[6] ? BRIGHT_LEVEL : DIM_LEVEL;
            end else begin
                colour = border;
                level  = DIM_LEVEL;
            end
            px.red         = colour[1] ? level : 8'd0;
            px.green       = colour[2] ? level : 8'd0;
            px.blue        = colour[0] ? level : 8'd0;
            px.attribute   = attr;
            px.from_screen = screen;
            px.last        = (k == 7);
            expected_pixels.push_back(px);
        end
    endfunction

    // Offer one input word, with random idle cycles ahead of it.
    task automatic send_word(logic mode, int addr, logic [7:0] data, int ln, int col,
                             logic [2:0] border);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, border, col[5:0], ln[8:0], data, addr[12:0]};
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_WRITE)
            store_byte(addr, data);
        else
            predict_cell(ln, col, border);
    endtask

    // Render fields of a write word carry random junk.
    task automatic write_byte(int addr, logic [7:0] data);
        send_word(MODE_WRITE, addr, data, $urandom_range(511), $urandom_range(63),
                  3'($urandom_range(7)));
    endtask

    // Write fields of a render word carry random junk.
    task automatic render_cell(int ln, int col, logic [2:0] border);
        send_word(MODE_RENDER, $urandom_range(8191), 8'($urandom), ln, col, border);
    endtask

    // Make sure both bytes a screen cell reads hold written data.
    task automatic load_cell(int ln, int col, bit rewrite);
        if (rewrite || !byte_written[attr_addr(ln, col)])
            write_byte(attr_addr(ln, col), 8'($urandom));
        if (rewrite || !byte_written[bitmap_addr(ln, col)])
            write_byte(bitmap_addr(ln, col), 8'($urandom));
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic compare_field(string what, int got, int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Store corners, plus writes past the end that must be ignored.
    task automatic test_store_writes();
        idle_pct  = 0;
        stall_pct = 0;
        write_byte(0, 8'hFF);
        write_byte(STORE_BYTES - 1, 8'hB8);
        write_byte(STORE_BYTES, 8'h5A);
        write_byte(8191, 8'hA5);
        write_byte(BITMAP_BYTES, 8'h47);
        write_byte(BITMAP_BYTES - 1, 8'h5A);
    endtask

    // First and last bitmap cells, and one in the middle with fresh bytes.
    task automatic test_screen_cells();
        render_cell(SCREEN_TOP, BORDER_COLS, 3'd0);
        render_cell(SCREEN_TOP + SCREEN_LINES - 1, BORDER_COLS + SCREEN_COLS - 1, 3'd7);
        load_cell(SCREEN_TOP + 77, BORDER_COLS + 13, 1'b1);
        render_cell(SCREEN_TOP + 77, BORDER_COLS + 13, 3'd5);
    endtask

    // Border edges above, below, left and right of the bitmap area.
    task automatic test_border_cells();
        render_cell(FIRST_LINE, 0, 3'd7);
        render_cell(SCREEN_TOP - 1, END_COL - 1, 3'd1);
        render_cell(SCREEN_TOP + SCREEN_LINES, BORDER_COLS, 3'd2);
        render_cell(END_LINE - 1, 20, 3'd4);
        render_cell(SCREEN_TOP, 0, 3'd6);
        render_cell(SCREEN_TOP + 100, BORDER_COLS - 1, 3'd3);
        render_cell(SCREEN_TOP + SCREEN_LINES - 1, BORDER_COLS + SCREEN_COLS, 3'd0);
        render_cell(SCREEN_TOP + 5, END_COL - 1, 3'd5);
    endtask

    // Cells outside the visible window give no pixels.
    task automatic test_outside_window();
        render_cell(FIRST_LINE - 1, 10, 3'd7);
        render_cell(END_LINE, 10, 3'd7);
        render_cell(511, 63, 3'd7);
        render_cell(SCREEN_TOP + 50, END_COL, 3'd7);
        render_cell(0, 63, 3'd0);
    endtask

    // Random writes, bitmap cells with their bytes loaded first, window cells and noise.
    task automatic test_random_traffic(int words, int idle, int stall);
        int ln;
        int col;
        int pick;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (words) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                write_byte($urandom_range(8191), 8'($urandom));
            end else begin
                if (pick < 65) begin
                    ln  = SCREEN_TOP + $urandom_range(SCREEN_LINES - 1);
                    col = BORDER_COLS + $urandom_range(SCREEN_COLS - 1);
                end else if (pick < 85) begin
                    ln  = $urandom_range(END_LINE - 1, FIRST_LINE);
                    col = $urandom_range(END_COL - 1);
                end else begin
                    ln  = $urandom_range(511);
                    col = $urandom_range(63);
                end
                if (is_screen(ln, col))
                    load_cell(ln, col, $urandom_range(2) == 0);
                render_cell(ln, col, 3'($urandom_range(7)));
            end
        end
    endtask

    // Sink holds off for a long stretch while cells keep coming.
    task automatic test_backpressure();
        int ln;
        int col;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (12) begin
            ln  = $urandom_range(END_LINE - 1, FIRST_LINE);
            col = $urandom_range(END_COL - 1);
            if (is_screen(ln, col))
                load_cell(ln, col, 1'b0);
            render_cell(ln, col, 3'($urandom_range(7)));
        end
    endtask

    // Sink readiness: random stalls, or a counted hold-off when requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare every output word against the oldest expected pixel.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel, data", m_tdata, 0);
            end else begin
                want_px = expected_pixels.pop_front();
                compare_field("red", int'(m_tdata[7:0]), int'(want_px.red));
                compare_field("green", int'(m_tdata[15:8]), int'(want_px.green));
                compare_field("blue", int'(m_tdata[23:16]), int'(want_px.blue));
                compare_field("attribute", int'(m_tdata[31:24]), int'(want_px.attribute));
                compare_field("from_screen", int'(m_tuser), int'(want_px.from_screen));
                compare_field("last", int'(m_tlast), int'(want_px.last));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_WRITE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_store_writes();
        test_screen_cells();
        test_border_cells();
        test_outside_window();
        test_random_traffic(35, 0, 0);
        test_random_traffic(35, 86, 0);
        test_random_traffic(35, 0, 86);
        test_random_traffic(35, 9, 9);
        test_backpressure();
        test_random_traffic(10, 0, 0);

        // Drain the remaining pixels, then allow the pipeline to settle.
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/ccvs_pkg.sv
design/ccvs_vram.sv
design/character_cell_video_scanout_core.sv
bench/character_cell_video_scanout_core_test.sv
